// ----- hdl/csm_pkg.sv -----
// ----------------------------------------------------------------------------
// csm_pkg
// Shared types and codes for the CSR sparse times dense matrix block.
// ----------------------------------------------------------------------------
package csm_pkg;

    localparam logic [31:0] FP_QNAN = 32'h7FC0_0000;

    localparam logic [1:0] MODE_LOAD = 2'd0;
    localparam logic [1:0] MODE_NZ   = 2'd1;
    localparam logic [1:0] MODE_EOR  = 2'd2;

    localparam logic [1:0] CFG_COLS  = 2'd0;
    localparam logic [1:0] CFG_ROWS  = 2'd1;

    // result forced by a special operand, bypasses rounding
    typedef struct packed {
        logic        hit;
        logic [31:0] bits;
    } fp_spec_t;

endpackage

// ----- hdl/csr_sparse_dense_matmul.sv -----
// ----------------------------------------------------------------------------
// csr_sparse_dense_matmul
// CSR sparse row times dense float32 weight matrix, one row at a time.
//
//   channel  handshake              payload
//   item     item_valid/item_ready  mode, row_index, col_index, value
//   result   res_valid/res_ready    column, sum, last, error
//   config   cfg_valid/cfg_ready    cfg_index, cfg_data
//
// A load or an out-of-range nonzero is handled in S_IDLE. A nonzero streams
// one column per cycle through the shared multiply-add pipeline until all are
// written back. An end of row reads each column in S_ERD and emits it in
// S_EOUT, holding on output stalls. Reset clears control and accumulator valid
// bits; the weight store holds no reset. Items wait while results stall.
// ----------------------------------------------------------------------------
module csr_sparse_dense_matmul import csm_pkg::*; #(
    parameter int MAX_WEIGHT_ROWS = 1024,
    parameter int MAX_COLS        = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  logic [1:0]  mode,
    input  logic [9:0]  row_index,
    input  logic [5:0]  col_index,
    input  logic [31:0] value,
    output logic        res_valid,
    input  logic        res_ready,
    output logic [5:0]  column,
    output logic [31:0] sum,
    output logic        last,
    output logic        error,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [10:0] cfg_data
);

    localparam int DEPTH = MAX_WEIGHT_ROWS * MAX_COLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam logic [6:0]  MAXC = 7'(MAX_COLS);
    localparam logic [16:0] MAXR = 17'(MAX_WEIGHT_ROWS);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MAC  = 4'b0010,
        S_ERD  = 4'b0100,
        S_EOUT = 4'b1000
    } state_t;

    state_t        state_reg, state_next;
    logic [6:0]    cols_reg;
    logic [10:0]   rows_reg;
    logic [31:0]   a_reg;
    logic [9:0]    row_reg;
    logic [6:0]    iss_n_reg, iss_n_next;
    logic [6:0]    wb_n_reg, wb_n_next;
    logic [6:0]    em_n_reg, em_n_next;
    logic          iss_vld_reg;
    logic [IW-1:0] iss_idx_reg;
    logic          err_reg, err_next;

    logic [6:0]    ncols;
    logic [16:0]   nrows;
    logic          item_acc;
    logic          row_bad;
    logic          ld_ok;
    logic          iss_go;
    logic          em_last;
    logic          clr;
    logic [31:0]   ld_addr_w, rd_addr_w;
    logic [31:0]   w_rd;
    logic [31:0]   acc_rd;
    logic          acc_rd_en;
    logic [IW-1:0] acc_rd_idx;
    logic          wb_vld;
    logic [IW-1:0] wb_idx;
    logic [31:0]   wb_sum;

    always_comb
    begin
        if (cols_reg == 7'd0)
        begin
            ncols = 7'd1;
        end
        else if (cols_reg > MAXC)
        begin
            ncols = MAXC;
        end
        else
        begin
            ncols = cols_reg;
        end
        if (rows_reg == 11'd0)
        begin
            nrows = 17'd1;
        end
        else if ({6'b0, rows_reg} > MAXR)
        begin
            nrows = MAXR;
        end
        else
        begin
            nrows = {6'b0, rows_reg};
        end
    end

    assign item_ready = (state_reg == S_IDLE);
    assign item_acc   = item_valid && item_ready;
    assign row_bad    = ({7'b0, row_index} >= nrows);
    assign ld_ok      = ({7'b0, row_index} < MAXR) && ({1'b0, col_index} < MAXC);
    assign iss_go     = (state_reg == S_MAC) && (iss_n_reg < ncols);
    assign em_last    = ((em_n_reg + 7'd1) == ncols);
    assign cfg_ready  = 1'b1;

    assign ld_addr_w = 32'(row_index) * 32'(MAX_COLS) + 32'(col_index);
    assign rd_addr_w = 32'(row_reg) * 32'(MAX_COLS) + 32'(iss_n_reg);

    always_comb
    begin
        state_next = state_reg;
        iss_n_next = iss_n_reg;
        wb_n_next  = wb_n_reg + 7'(wb_vld);
        em_n_next  = em_n_reg;
        err_next   = err_reg;
        clr        = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (item_acc)
                begin
                    case (mode)
                        MODE_NZ:
                        begin
                            if (row_bad)
                            begin
                                err_next = 1'b1;
                            end
                            else
                            begin
                                iss_n_next = '0;
                                wb_n_next  = '0;
                                state_next = S_MAC;
                            end
                        end
                        MODE_EOR:
                        begin
                            em_n_next  = '0;
                            state_next = S_ERD;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_MAC:
            begin
                if (iss_go)
                begin
                    iss_n_next = iss_n_reg + 7'd1;
                end
                if (wb_n_next == ncols)
                begin
                    state_next = S_IDLE;
                end
            end
            S_ERD:
            begin
                state_next = S_EOUT;
            end
            S_EOUT:
            begin
                if (res_ready)
                begin
                    if (em_last)
                    begin
                        clr        = 1'b1;
                        err_next   = 1'b0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        em_n_next  = em_n_reg + 7'd1;
                        state_next = S_ERD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cols_reg    <= 7'd16;
            rows_reg    <= 11'd1024;
            iss_n_reg   <= '0;
            wb_n_reg    <= '0;
            em_n_reg    <= '0;
            iss_vld_reg <= 1'b0;
            err_reg     <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            iss_n_reg   <= iss_n_next;
            wb_n_reg    <= wb_n_next;
            em_n_reg    <= em_n_next;
            iss_vld_reg <= iss_go;
            err_reg     <= err_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_COLS: cols_reg <= cfg_data[6:0];
                    CFG_ROWS: rows_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_acc)
        begin
            a_reg   <= value;
            row_reg <= row_index;
        end
        iss_idx_reg <= iss_n_reg[IW-1:0];
    end

    csm_wmem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_wmem (
        .clk     (clk),
        .wr_en   (item_acc && (mode == MODE_LOAD) && ld_ok),
        .wr_addr (ld_addr_w[AW-1:0]),
        .wr_data (value),
        .rd_en   (iss_go),
        .rd_addr (rd_addr_w[AW-1:0]),
        .rd_data (w_rd)
    );

    assign acc_rd_en  = iss_go || (state_reg == S_ERD);
    assign acc_rd_idx = (state_reg == S_MAC) ? iss_n_reg[IW-1:0] : em_n_reg[IW-1:0];

    csm_acc #(
        .DEPTH (MAX_COLS),
        .IW    (IW)
    ) u_acc (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wb_vld),
        .wr_idx  (wb_idx),
        .wr_data (wb_sum),
        .rd_en   (acc_rd_en),
        .rd_idx  (acc_rd_idx),
        .clr     (clr),
        .rd_data (acc_rd)
    );

    csm_fpu #(
        .IW (IW)
    ) u_fpu (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (iss_vld_reg),
        .in_a    (a_reg),
        .in_w    (w_rd),
        .in_acc  (acc_rd),
        .in_idx  (iss_idx_reg),
        .out_vld (wb_vld),
        .out_idx (wb_idx),
        .out_sum (wb_sum)
    );

    assign res_valid = (state_reg == S_EOUT);
    assign column    = em_n_reg[5:0];
    assign sum       = acc_rd;
    assign last      = em_last;
    assign error     = err_reg;

    a_wb_in_mac: assert property (@(posedge clk) disable iff (!rst_n)
        wb_vld |-> (state_reg == S_MAC))
        else $error("accumulator write outside nonzero processing");

    a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MAC) |-> (iss_n_reg <= ncols) && (wb_n_reg <= iss_n_reg))
        else $error("column issue count out of range");

    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_ready && last) |=> (item_ready && !error))
        else $error("row not closed after last word");

    a_bad_row: assert property (@(posedge clk) disable iff (!rst_n)
        (item_acc && (mode == MODE_NZ) && row_bad) |=> err_reg)
        else $error("row error flag not set");

endmodule

// ----- hdl/csm_wmem.sv -----
// ----------------------------------------------------------------------------
// csm_wmem
// Weight store: single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module csm_wmem #(
    parameter int DEPTH = 65536,
    parameter int AW    = 16
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [31:0]   wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [31:0]   rd_data
);

    logic [31:0] mem_reg [DEPTH];
    logic [31:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hdl/csm_acc.sv -----
// ----------------------------------------------------------------------------
// csm_acc
// Row accumulator memory. Entries without a valid bit read as +0.0;
// clearing drops all valid bits at once.
// ----------------------------------------------------------------------------
module csm_acc #(
    parameter int DEPTH = 64,
    parameter int IW    = 6
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  logic [IW-1:0] wr_idx,
    input  logic [31:0]   wr_data,
    input  logic          rd_en,
    input  logic [IW-1:0] rd_idx,
    input  logic          clr,
    output logic [31:0]   rd_data
);

    logic [31:0]      mem_reg [DEPTH];
    logic [DEPTH-1:0] vld_reg;
    logic [31:0]      rd_word_reg;
    logic             rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_idx] <= wr_data;
        end
        if (rd_en)
        begin
            rd_word_reg <= mem_reg[rd_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (clr)
            begin
                vld_reg <= '0;
            end
            else if (wr_en)
            begin
                vld_reg[wr_idx] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_reg <= vld_reg[rd_idx];
            end
        end
    end

    assign rd_data = rd_vld_reg ? rd_word_reg : 32'h0;

endmodule

// ----- hdl/csm_round.sv -----
// ----------------------------------------------------------------------------
// csm_round
// Two-stage normalize and round-to-nearest-even pack to float32.
// Value in = man * 2^(exp - 127 - (MW-1)). Special results pass through.
// ----------------------------------------------------------------------------
module csm_round import csm_pkg::*; #(
    parameter int MW = 48,
    parameter int TW = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_vld,
    input  logic               in_sign,
    input  logic signed [10:0] in_exp,
    input  logic [MW-1:0]      in_man,
    input  fp_spec_t           in_spec,
    input  logic [TW-1:0]      in_tag,
    output logic               out_vld,
    output logic [31:0]        out_bits,
    output logic [TW-1:0]      out_tag
);

    localparam int LZW = $clog2(MW) + 1;

    logic [LZW-1:0]     lz;
    logic               found;
    logic [MW-1:0]      norm;

    logic               s1_vld_reg;
    logic               s1_sign_reg;
    logic signed [10:0] s1_eb_reg;
    logic [MW-1:0]      s1_man_reg;
    logic               s1_zero_reg;
    fp_spec_t           s1_spec_reg;
    logic [TW-1:0]      s1_tag_reg;

    logic [LZW:0]       sh;
    logic [MW-1:0]      ms;
    logic               lost;
    logic [23:0]        m24;
    logic               rbit;
    logic               sbit;
    logic               inc;
    logic [7:0]         ef;
    logic [30:0]        packed_w;
    logic [31:0]        res;

    logic               out_vld_reg;
    logic [31:0]        out_bits_reg;
    logic [TW-1:0]      out_tag_reg;

    always_comb
    begin
        lz    = '0;
        found = 1'b0;
        for (int i = MW - 1; i >= 0; i--)
        begin
            if (!found && in_man[i])
            begin
                lz    = LZW'(MW - 1 - i);
                found = 1'b1;
            end
        end
        norm = in_man << lz;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg  <= in_vld;
            out_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_sign_reg <= in_sign;
        s1_eb_reg   <= in_exp - $signed(11'(lz));
        s1_man_reg  <= norm;
        s1_zero_reg <= (in_man == '0);
        s1_spec_reg <= in_spec;
        s1_tag_reg  <= in_tag;
    end

    always_comb
    begin
        if (s1_eb_reg > 11'sd0)
        begin
            sh = '0;
        end
        else if (int'(s1_eb_reg) <= -MW)
        begin
            sh = (LZW+1)'(MW);
        end
        else
        begin
            sh = (LZW+1)'(11'sd1 - s1_eb_reg);
        end
        ms       = s1_man_reg >> sh;
        lost     = |(s1_man_reg & ~({MW{1'b1}} << sh));
        m24      = ms[MW-1 -: 24];
        rbit     = ms[MW-25];
        sbit     = lost | (|ms[MW-26:0]);
        inc      = rbit & (sbit | m24[0]);
        ef       = (s1_eb_reg > 11'sd0) ? s1_eb_reg[7:0] : 8'h00;
        packed_w = {ef, m24[22:0]} + 31'(inc);
        if (s1_spec_reg.hit)
        begin
            res = s1_spec_reg.bits;
        end
        else if (s1_zero_reg)
        begin
            res = {s1_sign_reg, 31'h0};
        end
        else if (s1_eb_reg >= 11'sd255)
        begin
            res = {s1_sign_reg, 8'hFF, 23'h0};
        end
        else
        begin
            res = {s1_sign_reg, packed_w};
        end
    end

    always_ff @(posedge clk)
    begin
        out_bits_reg <= res;
        out_tag_reg  <= s1_tag_reg;
    end

    assign out_vld  = out_vld_reg;
    assign out_bits = out_bits_reg;
    assign out_tag  = out_tag_reg;

endmodule

// ----- hdl/csm_fpu.sv -----
// ----------------------------------------------------------------------------
// csm_fpu
// Pipelined multiply then add, each rounded to nearest even:
// out = acc + (a * w). One column enters per cycle.
// ----------------------------------------------------------------------------
module csm_fpu import csm_pkg::*; #(
    parameter int IW = 6
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_vld,
    input  logic [31:0]   in_a,
    input  logic [31:0]   in_w,
    input  logic [31:0]   in_acc,
    input  logic [IW-1:0] in_idx,
    output logic          out_vld,
    output logic [IW-1:0] out_idx,
    output logic [31:0]   out_sum
);

    localparam int TW1 = 32 + IW;

    logic               nan_a, nan_w, inf_a, inf_w, zero_a, zero_w, msign;
    logic [23:0]        man_a, man_w;
    logic [7:0]         x_a, x_w;
    fp_spec_t           mspec;

    logic               m1_vld_reg;
    logic               m1_sign_reg;
    logic signed [10:0] m1_exp_reg;
    logic [47:0]        m1_man_reg;
    fp_spec_t           m1_spec_reg;
    logic [TW1-1:0]     m1_tag_reg;

    logic               p_vld;
    logic [31:0]        p_bits;
    logic [TW1-1:0]     p_tag;

    logic [31:0]        op_a, op_b;
    logic               an_nan, bn_nan, an_inf, bn_inf, a_big;
    logic [23:0]        an_man, bn_man;
    logic [7:0]         an_x, bn_x;
    fp_spec_t           aspec;

    logic               a1_vld_reg;
    logic               a1_sl_reg, a1_ss_reg;
    logic [23:0]        a1_ml_reg, a1_ms_reg;
    logic [7:0]         a1_xl_reg, a1_d_reg;
    fp_spec_t           a1_spec_reg;
    logic [IW-1:0]      a1_idx_reg;

    logic [26:0]        full_s, algn, mlx;
    logic               stky;
    logic [27:0]        sum28;

    logic               a2_vld_reg;
    logic               a2_sign_reg;
    logic signed [10:0] a2_exp_reg;
    logic [27:0]        a2_man_reg;
    fp_spec_t           a2_spec_reg;
    logic [IW-1:0]      a2_idx_reg;

    function automatic logic is_nan(input logic [31:0] f);
        return (f[30:23] == 8'hFF) && (f[22:0] != 23'h0);
    endfunction

    function automatic logic is_inf(input logic [31:0] f);
        return (f[30:23] == 8'hFF) && (f[22:0] == 23'h0);
    endfunction

    function automatic logic [7:0] exp_of(input logic [31:0] f);
        return (f[30:23] == 8'h00) ? 8'h01 : f[30:23];
    endfunction

    // multiply front end
    always_comb
    begin
        nan_a  = is_nan(in_a);
        nan_w  = is_nan(in_w);
        inf_a  = is_inf(in_a);
        inf_w  = is_inf(in_w);
        zero_a = (in_a[30:0] == 31'h0);
        zero_w = (in_w[30:0] == 31'h0);
        man_a  = {in_a[30:23] != 8'h00, in_a[22:0]};
        man_w  = {in_w[30:23] != 8'h00, in_w[22:0]};
        x_a    = exp_of(in_a);
        x_w    = exp_of(in_w);
        msign  = in_a[31] ^ in_w[31];
        if (nan_a || nan_w || (inf_a && zero_w) || (zero_a && inf_w))
        begin
            mspec = '{hit: 1'b1, bits: FP_QNAN};
        end
        else if (inf_a || inf_w)
        begin
            mspec = '{hit: 1'b1, bits: {msign, 8'hFF, 23'h0}};
        end
        else if (zero_a || zero_w)
        begin
            mspec = '{hit: 1'b1, bits: {msign, 31'h0}};
        end
        else
        begin
            mspec = '{hit: 1'b0, bits: 32'h0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_vld_reg <= 1'b0;
            a1_vld_reg <= 1'b0;
            a2_vld_reg <= 1'b0;
        end
        else
        begin
            m1_vld_reg <= in_vld;
            a1_vld_reg <= p_vld;
            a2_vld_reg <= a1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        m1_sign_reg <= msign;
        m1_exp_reg  <= $signed({3'b000, x_a}) + $signed({3'b000, x_w}) - 11'sd126;
        m1_man_reg  <= man_a * man_w;
        m1_spec_reg <= mspec;
        m1_tag_reg  <= {in_acc, in_idx};
    end

    csm_round #(
        .MW (48),
        .TW (TW1)
    ) u_rnd_mul (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (m1_vld_reg),
        .in_sign  (m1_sign_reg),
        .in_exp   (m1_exp_reg),
        .in_man   (m1_man_reg),
        .in_spec  (m1_spec_reg),
        .in_tag   (m1_tag_reg),
        .out_vld  (p_vld),
        .out_bits (p_bits),
        .out_tag  (p_tag)
    );

    // add: order by magnitude
    always_comb
    begin
        op_a   = p_tag[TW1-1:IW];
        op_b   = p_bits;
        an_nan = is_nan(op_a);
        bn_nan = is_nan(op_b);
        an_inf = is_inf(op_a);
        bn_inf = is_inf(op_b);
        an_man = {op_a[30:23] != 8'h00, op_a[22:0]};
        bn_man = {op_b[30:23] != 8'h00, op_b[22:0]};
        an_x   = exp_of(op_a);
        bn_x   = exp_of(op_b);
        a_big  = (op_a[30:0] >= op_b[30:0]);
        if (an_nan || bn_nan || (an_inf && bn_inf && (op_a[31] != op_b[31])))
        begin
            aspec = '{hit: 1'b1, bits: FP_QNAN};
        end
        else if (an_inf)
        begin
            aspec = '{hit: 1'b1, bits: op_a};
        end
        else if (bn_inf)
        begin
            aspec = '{hit: 1'b1, bits: op_b};
        end
        else
        begin
            aspec = '{hit: 1'b0, bits: 32'h0};
        end
    end

    always_ff @(posedge clk)
    begin
        a1_sl_reg   <= a_big ? op_a[31] : op_b[31];
        a1_ss_reg   <= a_big ? op_b[31] : op_a[31];
        a1_ml_reg   <= a_big ? an_man : bn_man;
        a1_ms_reg   <= a_big ? bn_man : an_man;
        a1_xl_reg   <= a_big ? an_x : bn_x;
        a1_d_reg    <= a_big ? (an_x - bn_x) : (bn_x - an_x);
        a1_spec_reg <= aspec;
        a1_idx_reg  <= p_tag[IW-1:0];
    end

    // add: align and sum, three guard bits
    always_comb
    begin
        full_s = {a1_ms_reg, 3'b000};
        mlx    = {a1_ml_reg, 3'b000};
        if (a1_d_reg >= 8'd27)
        begin
            algn = '0;
            stky = |a1_ms_reg;
        end
        else
        begin
            algn = full_s >> a1_d_reg[4:0];
            stky = |(full_s & ~({27{1'b1}} << a1_d_reg[4:0]));
        end
        if (a1_sl_reg ^ a1_ss_reg)
        begin
            sum28 = {1'b0, mlx} - {1'b0, algn | 27'(stky)};
        end
        else
        begin
            sum28 = {1'b0, mlx} + {1'b0, algn | 27'(stky)};
        end
    end

    always_ff @(posedge clk)
    begin
        a2_sign_reg <= (sum28 == '0) ? (a1_sl_reg & a1_ss_reg) : a1_sl_reg;
        a2_exp_reg  <= $signed({3'b000, a1_xl_reg}) + 11'sd1;
        a2_man_reg  <= sum28;
        a2_spec_reg <= a1_spec_reg;
        a2_idx_reg  <= a1_idx_reg;
    end

    csm_round #(
        .MW (28),
        .TW (IW)
    ) u_rnd_add (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (a2_vld_reg),
        .in_sign  (a2_sign_reg),
        .in_exp   (a2_exp_reg),
        .in_man   (a2_man_reg),
        .in_spec  (a2_spec_reg),
        .in_tag   (a2_idx_reg),
        .out_vld  (out_vld),
        .out_bits (out_sum),
        .out_tag  (out_idx)
    );

endmodule

// ----- bench/csr_sparse_dense_matmul_chk.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csr_sparse_dense_matmul_chk
// Watches the item, config and result channels of the sparse times dense
// block, keeps its own weight store, row sums and error flag, rounds every
// float32 multiply and add to nearest even, and compares each result word
// field by field against the oldest predicted one.
// ----------------------------------------------------------------------------
module csr_sparse_dense_matmul_chk import csm_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    input  logic        item_ready,
    input  logic [1:0]  mode,
    input  logic [9:0]  row_index,
    input  logic [5:0]  col_index,
    input  logic [31:0] value,
    input  logic        res_valid,
    input  logic        res_ready,
    input  logic [5:0]  column,
    input  logic [31:0] sum,
    input  logic        last,
    input  logic        error,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [10:0] cfg_data,
    output int          fail_count,
    output int          pending
);

    typedef struct packed {
        logic [5:0]  column;
        logic [31:0] sum;
        logic        last;
        logic        error;
    } out_word_t;

    logic [31:0] weights [0:65535];
    logic [31:0] row_sums [0:63];
    logic        row_bad;
    logic [6:0]  n_cols;
    logic [10:0] n_rows;
    out_word_t   sums_due [$];

    function automatic real f32_to_real(logic [31:0] f);
        logic        s;
        logic [7:0]  e;
        logic [23:0] m;
        int          ex;
        s = f[31];
        e = f[30:23];
        m = {1'b0, f[22:0]};
        if (e == 8'hFF)
            return $bitstoreal({s, 11'h7FF, (m != 0), 51'd0});
        if (e == 8'd0) begin
            if (m == 0)
                return $bitstoreal({s, 63'd0});
            ex = -126;
            while (!m[23]) begin
                m = m << 1;
                ex = ex - 1;
            end
        end else begin
            ex = int'(e) - 127;
            m[23] = 1'b1;
        end
        ex = ex + 1023;
        return $bitstoreal({s, ex[10:0], m[22:0], 29'd0});
    endfunction

    function automatic logic [31:0] real_to_f32(real r);
        logic [63:0] d;
        logic        s;
        int          e;
        int          fe;
        int          sh;
        logic [63:0] sig;
        logic [63:0] q;
        logic [63:0] rem;
        logic [63:0] half;
        d = $realtobits(r);
        s = d[63];
        e = int'(d[62:52]);
        if (e == 2047)
            return (d[51:0] != 0) ? FP_QNAN : {s, 8'hFF, 23'd0};
        if (e == 0)
            return {s, 31'd0};
        sig = {11'd0, 1'b1, d[51:0]};
        fe = e - 1023 + 127;
        sh = (fe >= 1) ? 29 : 30 - fe;
        if (sh > 60)
            sh = 60;
        q = sig >> sh;
        rem = sig & ((64'd1 << sh) - 1);
        half = 64'd1 << (sh - 1);
        if (rem > half || (rem == half && q[0]))
            q = q + 1;
        if (fe >= 1) begin
            if (q[24]) begin
                q = q >> 1;
                fe = fe + 1;
            end
            if (fe >= 255)
                return {s, 8'hFF, 23'd0};
            return {s, fe[7:0], q[22:0]};
        end
        return {s, q[30:0]};
    endfunction

    function automatic logic [31:0] fmul(logic [31:0] a, logic [31:0] b);
        return real_to_f32(f32_to_real(a) * f32_to_real(b));
    endfunction

    function automatic logic [31:0] fadd(logic [31:0] a, logic [31:0] b);
        return real_to_f32(f32_to_real(a) + f32_to_real(b));
    endfunction

    function automatic int cols_eff();
        if (n_cols == 0)
            return 1;
        return (n_cols > 64) ? 64 : int'(n_cols);
    endfunction

    function automatic int rows_eff();
        if (n_rows == 0)
            return 1;
        return (n_rows > 1024) ? 1024 : int'(n_rows);
    endfunction

    task automatic take_item();
        int        nc;
        out_word_t w;
        nc = cols_eff();
        case (mode)
            MODE_LOAD:
                weights[{row_index, col_index}] = value;
            MODE_NZ:
                if (int'(row_index) >= rows_eff())
                    row_bad = 1'b1;
                else
                    for (int n = 0; n < nc; n++)
                        row_sums[n] = fadd(row_sums[n],
                                           fmul(value, weights[{row_index, 6'(n)}]));
            MODE_EOR: begin
                for (int n = 0; n < nc; n++) begin
                    w.column = 6'(n);
                    w.sum = row_sums[n];
                    w.last = (n == nc - 1);
                    w.error = row_bad;
                    sums_due.push_back(w);
                    row_sums[n] = 32'd0;
                end
                row_bad = 1'b0;
            end
            default: ;
        endcase
    endtask

    task automatic check_word();
        out_word_t w;
        if (sums_due.size() == 0) begin
            $error("unexpected result word column %0d sum %h", column, sum);
            fail_count++;
            return;
        end
        w = sums_due.pop_front();
        if (column !== w.column) begin
            $error("column exp %0d got %0d", w.column, column);
            fail_count++;
        end
        if (sum !== w.sum) begin
            $error("sum exp %h got %h", w.sum, sum);
            fail_count++;
        end
        if (last !== w.last) begin
            $error("last exp %b got %b", w.last, last);
            fail_count++;
        end
        if (error !== w.error) begin
            $error("error exp %b got %b", w.error, error);
            fail_count++;
        end
    endtask

    initial begin
        fail_count = 0;
        pending = 0;
        row_bad = 1'b0;
        n_cols = 7'd16;
        n_rows = 11'd1024;
        for (int n = 0; n < 64; n++)
            row_sums[n] = 32'd0;
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_COLS)
                    n_cols = cfg_data[6:0];
                else if (cfg_index == CFG_ROWS)
                    n_rows = cfg_data;
            end
            if (item_valid && item_ready)
                take_item();
            if (res_valid && res_ready)
                check_word();
            pending = sums_due.size();
        end
    end

endmodule

// ----- bench/csr_sparse_dense_matmul_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csr_sparse_dense_matmul_tb
// Drives weight loads, sparse rows and end-of-row words into the block under
// a series of column and row settings, with bursty input and a stalling
// result side; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module csr_sparse_dense_matmul_tb import csm_pkg::*; ();

    logic        clk;
    logic        rst_n;
    logic        item_valid;
    logic        item_ready;
    logic [1:0]  mode;
    logic [9:0]  row_index;
    logic [5:0]  col_index;
    logic [31:0] value;
    logic        res_valid;
    logic        res_ready;
    logic [5:0]  column;
    logic [31:0] sum;
    logic        last;
    logic        error;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [10:0] cfg_data;
    int          fail_count;
    int          pending;

    bit          loaded [0:65535];
    int          n_cols;
    int          n_rows;
    int          burst_left;
    int          stall_kind;
    int          stall_left;

    csr_sparse_dense_matmul u_dut (.*);

    csr_sparse_dense_matmul_chk u_chk (.*);

    initial begin
        clk = 1'b0;
        forever begin
            #2 clk = 1'b1;
            #2 clk = 1'b0;
        end
    end

    initial begin
        #20ms;
        $display("[csr_sparse_dense_matmul] ERROR");
        $finish;
    end

    // result side: runs of always-ready, random, and short hard stalls
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            res_ready <= 1'b0;
            stall_kind <= 0;
            stall_left <= 0;
        end else begin
            if (stall_left == 0) begin
                stall_kind <= $urandom_range(0, 2);
                stall_left <= $urandom_range(5, 60);
            end else begin
                stall_left <= stall_left - 1;
            end
            case (stall_kind)
                0: res_ready <= 1'b1;
                1: res_ready <= $urandom_range(0, 1);
                default: res_ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    function automatic logic [31:0] rand_f32();
        logic [31:0] specials [0:9];
        specials = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
                     32'h7FC0_0001, 32'h0000_0001, 32'h807F_FFFF, 32'h7F7F_FFFF,
                     32'h0080_0000, 32'h3F80_0000};
        case ($urandom_range(0, 7))
            0: return specials[$urandom_range(0, 9)];
            1: return $urandom;
            default: return {1'($urandom), 8'($urandom_range(100, 150)), 23'($urandom)};
        endcase
    endfunction

    task automatic send(logic [1:0] m, logic [9:0] r, logic [5:0] c, logic [31:0] v);
        if (burst_left == 0) begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge clk);
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        item_valid <= 1'b1;
        mode <= m;
        row_index <= r;
        col_index <= c;
        value <= v;
        if (m == MODE_LOAD)
            loaded[{r, c}] = 1'b1;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
    endtask

    task automatic drain();
        item_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [10:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == CFG_COLS)
            n_cols = (d[6:0] == 0) ? 1 : ((d[6:0] > 64) ? 64 : int'(d[6:0]));
        else if (idx == CFG_ROWS)
            n_rows = (d == 0) ? 1 : ((d > 1024) ? 1024 : int'(d));
        @(posedge clk);
    endtask

    function automatic bit row_ready(int k);
        for (int n = 0; n < n_cols; n++)
            if (!loaded[k * 64 + n])
                return 1'b0;
        return 1'b1;
    endfunction

    // a usable weight row, or an out-of-range one when asked and possible
    function automatic logic [9:0] pick_row(bit bad);
        int k;
        if (bad && n_rows < 1024)
            return 10'($urandom_range(n_rows, 1023));
        k = $urandom_range(0, 1023);
        if (k < n_rows && row_ready(k))
            return 10'(k);
        k = $urandom_range(0, 1);
        return (k < n_rows) ? 10'(k) : 10'd0;
    endfunction

    task automatic random_phase(int count);
        int nnz;
        int i;
        i = 0;
        while (i < count) begin
            case ($urandom_range(0, 9))
                0, 1: begin
                    send(MODE_LOAD, 10'($urandom_range(0, 5)), 6'($urandom), rand_f32());
                    i++;
                end
                2: begin
                    send(MODE_LOAD, 10'($urandom), 6'($urandom), $urandom);
                    i++;
                end
                3:
                    send(2'd3, 10'($urandom), 6'($urandom), $urandom);
                default: begin
                    nnz = $urandom_range(0, 5);
                    repeat (nnz)
                        send(MODE_NZ, pick_row($urandom_range(0, 9) == 0),
                             6'($urandom), rand_f32());
                    send(MODE_EOR, 10'($urandom), 6'($urandom), $urandom);
                    i += nnz + 1;
                end
            endcase
        end
        drain();
    endtask

    initial begin
        rst_n = 1'b0;
        item_valid = 1'b0;
        mode = MODE_LOAD;
        row_index = '0;
        col_index = '0;
        value = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_COLS;
        cfg_data = '0;
        burst_left = 0;
        n_cols = 16;
        n_rows = 1024;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // weight rows used throughout
        for (int k = 0; k < 2; k++)
            for (int n = 0; n < 64; n++)
                send(MODE_LOAD, 10'(k), 6'(n), rand_f32());
        for (int n = 0; n < 16; n++)
            send(MODE_LOAD, 10'd2, 6'(n), rand_f32());
        for (int n = 0; n < 16; n++)
            send(MODE_LOAD, 10'd1023, 6'(n), {1'($urandom), 8'd127, 23'($urandom)});

        // directed: empty row, extremes, NaN and infinities, bad index, unused mode
        send(MODE_EOR, 10'd0, 6'd0, 32'd0);
        send(MODE_NZ, 10'd1023, 6'd63, 32'h7F7F_FFFF);
        send(MODE_NZ, 10'd1023, 6'd0, 32'hFF7F_FFFF);
        send(MODE_NZ, 10'd0, 6'd0, 32'h7F80_0000);
        send(MODE_EOR, 10'd1023, 6'd63, 32'hFFFF_FFFF);
        send(MODE_NZ, 10'd1, 6'd0, 32'h0000_0001);
        send(MODE_NZ, 10'd2, 6'd0, 32'h7FFF_FFFF);
        send(2'd3, 10'd1, 6'd5, 32'h3F80_0000);
        send(MODE_EOR, 10'd0, 6'd0, 32'd0);
        drain();
        write_reg(CFG_ROWS, 11'd2);
        send(MODE_NZ, 10'd1, 6'd0, 32'h3F80_0000);
        send(MODE_NZ, 10'd2, 6'd0, 32'h3F80_0000);
        send(MODE_NZ, 10'd1023, 6'd0, 32'h3F80_0000);
        send(MODE_EOR, 10'd0, 6'd0, 32'd0);
        send(MODE_NZ, 10'd0, 6'd0, 32'hBF80_0000);
        send(MODE_EOR, 10'd0, 6'd0, 32'd0);
        drain();

        write_reg(CFG_COLS, 11'd64);
        write_reg(CFG_ROWS, 11'd1024);
        random_phase(20);
        write_reg(CFG_COLS, 11'd1);
        write_reg(CFG_ROWS, 11'd1);
        random_phase(20);
        write_reg(CFG_COLS, 11'd0);
        write_reg(CFG_ROWS, 11'd0);
        random_phase(15);
        write_reg(CFG_COLS, 11'h7FF);
        write_reg(CFG_ROWS, 11'h7FF);
        random_phase(20);
        write_reg(CFG_COLS, 11'd7);
        write_reg(CFG_ROWS, 11'd3);
        random_phase(20);
        write_reg(CFG_COLS, 11'd16);
        write_reg(CFG_ROWS, 11'd1023);
        random_phase(10);

        if (fail_count == 0)
            $display("[csr_sparse_dense_matmul] OK");
        else
            $display("[csr_sparse_dense_matmul] ERROR");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/csm_pkg.sv
hdl/csm_wmem.sv
hdl/csm_acc.sv
hdl/csm_round.sv
hdl/csm_fpu.sv
hdl/csr_sparse_dense_matmul.sv
bench/csr_sparse_dense_matmul_chk.sv
bench/csr_sparse_dense_matmul_tb.sv
